[src/msad_pkg.sv]
// ----------------------------------------------------------------------------
// msad_pkg
// Shared types and constants for the moving-average spike detector.
// ----------------------------------------------------------------------------
package msad_pkg;

    // Default parameter values
    localparam int DEF_MAX_WINDOW  = 64;
    localparam int DEF_SAMPLE_BITS = 32;

    // Fixed field widths
    localparam int LEN_BITS   = 7;   // window_length register
    localparam int RATIO_BITS = 16;  // spike_ratio register, Q8.8
    localparam int FRAC_BITS  = 8;   // fraction bits of the average
    localparam int AVG_BITS   = 40;  // average_q8 field, Q32.8

    // Configuration port
    localparam int CFG_DATA_BITS = 16;

    // Register reset values
    localparam logic [LEN_BITS-1:0]   LEN_RESET   = 7'd10;
    localparam logic [RATIO_BITS-1:0] RATIO_RESET = 16'd512;  // 2.0

    // Result stream tdata width, whole bytes
    localparam int M_TDATA_BITS = ((AVG_BITS + 7) / 8) * 8;

    // Register indexes
    typedef enum logic [0:0] {
        REG_WINDOW_LENGTH = 1'b0,
        REG_SPIKE_RATIO   = 1'b1
    } cfg_index_t;

endpackage : msad_pkg

[src/msad_ram.sv]
// ----------------------------------------------------------------------------
// msad_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module msad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : msad_ram

[src/msad_div.sv]
// ----------------------------------------------------------------------------
// msad_div
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module msad_div #(
    parameter int DIVIDEND_W = 46,
    parameter int DIVISOR_W  = 7
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] work_reg, work_next;   // dividend out, quotient in
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, work_reg[DIVIDEND_W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            work_next = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            work_next = {work_reg[DIVIDEND_W-2:0], fits};
            rem_next  = fits ? DIVISOR_W'(trial - {1'b0, dsr_reg}) : DIVISOR_W'(trial);
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = work_reg;

endmodule : msad_div

[src/moving_average_spike_detector.sv]
// ----------------------------------------------------------------------------
// moving_average_spike_detector
// Windowed volume average in Q32.8 with a ratio-based spike flag.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  s_       in   tdata: volume
//  m_       out  tdata: average_q8; tuser: average_valid, spike
//  cfg_     in   write-only: window_length (0), spike_ratio (1)
//
// Each input beat passes the ring update, the multiply step and the bit-serial
// divider for sum*256/window_length before its result is registered; the next
// beat is taken only once the state machine is back in idle.
// The ring lives in a RAM; one read and one write per beat.
// Reset is synchronous; ready is low while a beat is in work.
// One finished result waits in the output register; a new beat is taken
// meanwhile and only stalls at its own end if that result is still held.
// ----------------------------------------------------------------------------
module moving_average_spike_detector #(
    parameter int MAX_WINDOW  = msad_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = msad_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,   // volume
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [msad_pkg::M_TDATA_BITS-1:0]    m_tdata,   // average_q8
    output logic [1:0]                           m_tuser,   // average_valid, spike
    // configuration
    input  logic                                 cfg_we,
    input  msad_pkg::cfg_index_t                 cfg_index,
    input  logic [msad_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

    import msad_pkg::*;

    localparam int ADDR_W = $clog2(MAX_WINDOW);
    localparam int SUM_W  = SAMPLE_BITS + ADDR_W;
    localparam int DIVD_W = SUM_W + FRAC_BITS;
    localparam int MA_W   = SAMPLE_BITS + LEN_BITS;
    localparam int PA_W   = MA_W + FRAC_BITS;
    localparam int PB_W   = RATIO_BITS + SUM_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_MULT,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t                  state_reg, state_next;
    logic [LEN_BITS-1:0]     window_length_reg, window_length_next;
    logic [RATIO_BITS-1:0]   spike_ratio_reg, spike_ratio_next;
    logic [SUM_W-1:0]        window_sum_reg, window_sum_next;
    logic [ADDR_W-1:0]       write_slot_reg, write_slot_next;
    logic [LEN_BITS-1:0]     seen_count_reg, seen_count_next;
    logic [ADDR_W-1:0]       slot_reg, slot_next;
    logic [SAMPLE_BITS-1:0]  vol_reg, vol_next;
    logic [PA_W-1:0]         prod_a_reg, prod_a_next;
    logic [PB_W-1:0]         prod_b_reg, prod_b_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [AVG_BITS-1:0]     avg_reg, avg_next;
    logic                    avg_valid_reg, avg_valid_next;
    logic                    spike_reg, spike_next;

    logic [LEN_BITS-1:0]     period;
    logic [ADDR_W-1:0]       slot_now;
    logic                    window_full;
    logic                    in_accept;
    logic [SAMPLE_BITS-1:0]  ram_rdata;
    logic [SAMPLE_BITS-1:0]  old_sample;
    logic [MA_W-1:0]         mul_a;
    logic [PB_W-1:0]         mul_b;
    logic                    div_start;
    logic                    div_busy;
    logic [DIVD_W-1:0]       div_quot;

    // Effective window length: zero acts as one, large values saturate
    always_comb begin
        if (window_length_reg == '0) begin
            period = LEN_BITS'(1);
        end else if (32'(window_length_reg) > 32'(MAX_WINDOW)) begin
            period = LEN_BITS'(MAX_WINDOW);
        end else begin
            period = window_length_reg;
        end
    end

    // Slot for the incoming sample; wraps if the window shrank
    assign slot_now    = (32'(write_slot_reg) >= 32'(period)) ? '0 : write_slot_reg;
    assign window_full = (seen_count_reg >= period);
    assign in_accept   = s_tvalid && (state_reg == ST_IDLE);
    assign old_sample  = window_full ? ram_rdata : '0;

    // Products for the spike compare
    assign mul_a = vol_reg * period;
    assign mul_b = spike_ratio_reg * window_sum_reg;

    assign div_start = (state_reg == ST_MULT);

    // Sample ring
    msad_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (state_reg == ST_UPDATE),
        .wr_addr (slot_reg),
        .wr_data (vol_reg),
        .rd_en   (in_accept),
        .rd_addr (slot_now),
        .rd_data (ram_rdata)
    );

    // Serial divider: sum * 256 / period
    msad_div #(
        .DIVIDEND_W (DIVD_W),
        .DIVISOR_W  (LEN_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({window_sum_reg, FRAC_BITS'(0)}),
        .divisor  (period),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    // Sequencer and history update
    always_comb begin
        state_next         = state_reg;
        window_length_next = window_length_reg;
        spike_ratio_next   = spike_ratio_reg;
        window_sum_next    = window_sum_reg;
        write_slot_next    = write_slot_reg;
        seen_count_next    = seen_count_reg;
        slot_next          = slot_reg;
        vol_next           = vol_reg;
        prod_a_next        = prod_a_reg;
        prod_b_next        = prod_b_reg;
        m_tvalid_next      = m_tvalid_reg && !m_tready;
        avg_next           = avg_reg;
        avg_valid_next     = avg_valid_reg;
        spike_next         = spike_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    vol_next   = s_tdata[SAMPLE_BITS-1:0];
                    slot_next  = slot_now;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // ring read data is valid here
                window_sum_next = window_sum_reg - SUM_W'(old_sample) + SUM_W'(vol_reg);
                if (32'(slot_reg) + 32'd1 >= 32'(period)) begin
                    write_slot_next = '0;
                end else begin
                    write_slot_next = slot_reg + 1'b1;
                end
                if (!window_full) begin
                    seen_count_next = seen_count_reg + 1'b1;
                end
                state_next = ST_MULT;
            end
            ST_MULT: begin
                prod_a_next = {mul_a, FRAC_BITS'(0)};
                prod_b_next = mul_b;
                state_next  = ST_DIV;
            end
            ST_DIV: begin
                if (!div_busy) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next  = 1'b1;
                    avg_valid_next = window_full;
                    avg_next       = window_full ? AVG_BITS'(div_quot) : '0;
                    spike_next     = window_full && (window_sum_reg != '0)
                                     && (PB_W'(prod_a_reg) > prod_b_reg);
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // The user must write configuration only while idle; the block itself does not enforce it
        if (cfg_we) begin
            case (cfg_index)
                REG_WINDOW_LENGTH: begin
                    window_length_next = cfg_wdata[LEN_BITS-1:0];
                    window_sum_next    = '0;
                    write_slot_next    = '0;
                    seen_count_next    = '0;
                end
                REG_SPIKE_RATIO: begin
                    spike_ratio_next = cfg_wdata[RATIO_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            window_length_reg <= LEN_RESET;
            spike_ratio_reg   <= RATIO_RESET;
            window_sum_reg    <= '0;
            write_slot_reg    <= '0;
            seen_count_reg    <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg         <= state_next;
            window_length_reg <= window_length_next;
            spike_ratio_reg   <= spike_ratio_next;
            window_sum_reg    <= window_sum_next;
            write_slot_reg    <= write_slot_next;
            seen_count_reg    <= seen_count_next;
            m_tvalid_reg      <= m_tvalid_next;
        end
        slot_reg      <= slot_next;
        vol_reg       <= vol_next;
        prod_a_reg    <= prod_a_next;
        prod_b_reg    <= prod_b_next;
        avg_reg       <= avg_next;
        avg_valid_reg <= avg_valid_next;
        spike_reg     <= spike_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_BITS'(avg_reg);
    assign m_tuser  = {spike_reg, avg_valid_reg};

endmodule : moving_average_spike_detector

[bench/tb_moving_average_spike_detector.sv]
// ----------------------------------------------------------------------------
// tb_moving_average_spike_detector
// Self-checking bench for the windowed volume average and spike flag.
// Volume beats go in on the s_ stream. Each beat is tracked by a scoreboard
// that keeps its own sample ring, running sum and register copies, and works
// out the Q32.8 average, the full-window flag and the spike flag it expects.
// Every m_ beat is checked field by field against the oldest expected beat.
// A short directed run comes first. It covers the reset defaults, extreme
// volumes, a window length of zero, ignored upper bits of a length write, ratio
// extremes, and a ratio change that keeps the history. Random phases follow,
// with fresh register settings and random idling on both streams.
// ----------------------------------------------------------------------------
module tb_moving_average_spike_detector;
    import msad_pkg::*;

    localparam int CLK_HALF   = 6;
    localparam int RING_DEPTH = DEF_MAX_WINDOW;
    localparam int N_SAMPLES  = 1850;
    localparam int TAIL_WAIT  = 60;

    typedef struct packed {
        logic [AVG_BITS-1:0] average_q8;
        logic                average_valid;
        logic                spike;
    } average_beat_t;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the window and checks result beats in order
    // ------------------------------------------------------------------------
    class spike_scoreboard;
        logic [LEN_BITS-1:0]   win_len;
        logic [RATIO_BITS-1:0] ratio;
        logic [31:0]           ring [RING_DEPTH];
        logic [63:0]           win_sum;
        int unsigned           slot;
        int unsigned           seen;
        average_beat_t         expected_averages [$];
        int                    errors;
        int                    checked;
        int                    full_count;
        int                    spike_count;

        function new();
            win_len     = LEN_RESET;
            ratio       = RATIO_RESET;
            win_sum     = '0;
            slot        = 0;
            seen        = 0;
            errors      = 0;
            checked     = 0;
            full_count  = 0;
            spike_count = 0;
            foreach (ring[i]) ring[i] = '0;
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40) $display("ERROR at %0t: %s", $time, what);
        endtask

        // register write; a new window length restarts the history
        function void set_register(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
            if (idx == REG_WINDOW_LENGTH) begin
                win_len = data[LEN_BITS-1:0];
                win_sum = '0;
                slot    = 0;
                seen    = 0;
            end else begin
                ratio = data[RATIO_BITS-1:0];
            end
        endfunction

        // one accepted volume beat
        function void take_volume(logic [31:0] vol);
            int unsigned   period;
            int unsigned   s;
            logic [63:0]   lhs;
            logic [63:0]   rhs;
            logic [63:0]   avg;
            average_beat_t beat;

            // zero length acts as one, long lengths saturate
            if (win_len == 0)
                period = 1;
            else if (win_len > RING_DEPTH)
                period = RING_DEPTH;
            else
                period = win_len;

            s = slot;
            if (s >= period) s = 0;
            if (seen >= period) win_sum -= 64'(ring[s]);
            ring[s] = vol;
            win_sum += 64'(vol);
            slot = (s + 1 >= period) ? 0 : s + 1;
            if (seen < period) seen++;

            beat = '0;
            beat.average_valid = (seen >= period);
            if (beat.average_valid) begin
                avg = (win_sum << FRAC_BITS) / 64'(period);
                beat.average_q8 = avg[AVG_BITS-1:0];
                if (win_sum != 0) begin
                    lhs = 64'(vol) * 64'(period) * 64'd256;
                    rhs = 64'(ratio) * win_sum;
                    beat.spike = (lhs > rhs);
                end
            end
            expected_averages.insert(expected_averages.size(), beat);
        endfunction

        task check_average(logic [AVG_BITS-1:0] avg, logic valid, logic spike);
            average_beat_t want;
            if (expected_averages.size() == 0) begin
                report($sformatf("result beat with nothing expected (avg %h)", avg));
            end else begin
                want = expected_averages.pop_front();
                checked++;
                if (want.average_valid) full_count++;
                if (want.spike) spike_count++;
                if (avg !== want.average_q8)
                    report($sformatf("average_q8 %h, expected %h", avg, want.average_q8));
                if (valid !== want.average_valid)
                    report($sformatf("average_valid %b, expected %b",
                                     valid, want.average_valid));
                if (spike !== want.spike)
                    report($sformatf("spike %b, expected %b (avg %h)",
                                     spike, want.spike, want.average_q8));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic                     aclk;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [31:0]              s_tdata   = '0;   // volume
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [M_TDATA_BITS-1:0]  m_tdata;          // average_q8
    logic [1:0]               m_tuser;          // average_valid, spike
    logic                     cfg_we    = 1'b0;
    cfg_index_t               cfg_index = REG_WINDOW_LENGTH;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    spike_scoreboard sb = new();

    int tx_idle_max = 11;
    int rx_idle_max = 11;
    int sent        = 0;
    int settings    = 1;

    moving_average_spike_detector u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Watchdog
    initial begin
        #(2 * CLK_HALF * 900_000);
        $display("Timeout: result stream stalled or too slow");
        $display("*** FAILED ***");
        $finish;
    end

    // Beat monitors on both streams
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.take_volume(s_tdata);
        if (aresetn && m_tvalid && m_tready)
            sb.check_average(m_tdata[AVG_BITS-1:0], m_tuser[0], m_tuser[1]);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // valid is only lowered when a gap follows, so back-to-back beats keep it high
    task send_volume(logic [31:0] vol);
        int gap;
        gap = (tx_idle_max == 0) ? 0 : $urandom_range(0, tx_idle_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= vol;
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task drive_ready();
        int gap;
        forever begin
            gap = (rx_idle_max == 0) ? 0 : $urandom_range(0, rx_idle_max);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    endtask

    // hold the sender until every expected beat is back; the first edge lets
    // the monitor log the last accepted beat
    task drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_averages.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // ratio always written; window length only when asked (clears history)
    task program_regs(bit with_len, logic [CFG_DATA_BITS-1:0] len_data,
                      logic [CFG_DATA_BITS-1:0] ratio_data);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SPIKE_RATIO;
        cfg_wdata <= ratio_data;
        @(posedge aclk);
        sb.set_register(REG_SPIKE_RATIO, ratio_data);
        if (with_len) begin
            cfg_index <= REG_WINDOW_LENGTH;
            cfg_wdata <= len_data;
            @(posedge aclk);
            sb.set_register(REG_WINDOW_LENGTH, len_data);
        end
        cfg_we <= 1'b0;
        settings++;
    endtask

    // level-based volume with noise, outliers and extremes
    function automatic logic [31:0] draw_volume(logic [31:0] base);
        logic [63:0] big;
        case ($urandom_range(0, 11))
            0:       big = 64'd0;
            1:       big = 64'hFFFF_FFFF;
            2:       big = 64'($urandom);
            3, 4:    big = 64'(base) * 64'($urandom_range(2, 12));
            default: big = 64'(base) + 64'($urandom_range(0, base >> 3));
        endcase
        return (big > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : big[31:0];
    endfunction

    initial drive_ready();

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [31:0]              base;
        logic [CFG_DATA_BITS-1:0] len_data;
        logic [CFG_DATA_BITS-1:0] ratio_data;
        logic [LEN_BITS-1:0]      len;
        bit                       with_len;
        int                       n;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: window of 10, ratio 2.0; fill, then an outlier
        send_volume(32'hFFFF_FFFF);
        for (int v = 0; v <= 8; v++) send_volume(32'(v));
        send_volume(32'd5000);
        send_volume(32'd0);

        // window length zero acts as one; ratio zero flags any nonzero sample
        drain();
        program_regs(1'b1, 16'd0, 16'd0);
        send_volume(32'd0);
        send_volume(32'd5);
        send_volume(32'hFFFF_FFFF);

        // upper data bits ignored: window of 2, ratio 1.0
        drain();
        program_regs(1'b1, 16'hFF82, 16'd256);
        send_volume(32'd4);
        send_volume(32'd4);
        send_volume(32'd4);
        send_volume(32'd9);

        // ratio change alone keeps the window history
        drain();
        program_regs(1'b0, 16'd0, 16'hFFFF);
        send_volume(32'd9);
        send_volume(32'd200);

        // random phases, each with its own settings
        while (sent < N_SAMPLES) begin
            drain();
            with_len = ($urandom_range(0, 4) != 0);
            case ($urandom_range(0, 7))
                0:       len = 7'd0;
                1:       len = 7'd1;
                2:       len = 7'(RING_DEPTH);
                3:       len = 7'($urandom_range(RING_DEPTH + 1, 127));
                4:       len = 7'($urandom_range(17, RING_DEPTH - 1));
                default: len = 7'($urandom_range(2, 16));
            endcase
            len_data = {9'($urandom_range(0, 511)), len};
            case ($urandom_range(0, 5))
                0:       ratio_data = 16'd0;
                1:       ratio_data = 16'hFFFF;
                2:       ratio_data = 16'($urandom_range(0, 65535));
                default: ratio_data = 16'($urandom_range(256, 1024));
            endcase
            program_regs(with_len, len_data, ratio_data);

            base = $urandom >> $urandom_range(0, 31);
            n = $urandom_range(30, 150);
            repeat (n) send_volume(draw_volume(base));
        end

        // let the last results through, then a quiet tail before the summary
        drain();
        repeat (TAIL_WAIT) @(posedge aclk);

        $display("Run covered %0d volume beats over %0d register settings.",
                 sb.checked, settings);
        $display("%0d beats had a full window, %0d raised the spike flag.",
                 sb.full_count, sb.spike_count);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule : tb_moving_average_spike_detector

[files.f]
src/msad_pkg.sv
src/msad_ram.sv
src/msad_div.sv
src/moving_average_spike_detector.sv
bench/tb_moving_average_spike_detector.sv
